/* rtl/bertlv_pkg.sv */
// Shared types and codes for the BER-TLV stream parser.
`default_nettype none
package bertlv_pkg;

   localparam int RSP_DEPTH_W = 4;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED = 3'd1;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
   localparam logic [2:0] ERR_OVERRUN   = 3'd3;
   localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;

   // tag and length byte fields
   localparam logic [4:0] TAG_LOW_ALL  = 5'h1F;
   localparam int         TAG_CONS_BIT = 5;
   localparam int         MORE_BIT     = 7;

   typedef enum logic [4:0] {
      PH_TAG_FIRST = 5'b00001,
      PH_TAG_MORE  = 5'b00010,
      PH_LEN_FIRST = 5'b00100,
      PH_LEN_MORE  = 5'b01000,
      PH_VALUE     = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [31:0]            tag;
      logic [2:0]             tag_bytes;
      logic [31:0]            length;
      logic                   constructed;
      logic [RSP_DEPTH_W-1:0] depth;
      logic [7:0]             value_byte;
      logic                   value_last;
      logic                   message_end;
      logic [2:0]             error_code;
   } rsp_type;

   // parser to nesting stack
   typedef struct packed {
      logic        restart;
      logic        push;
      logic        pop;
      logic [31:0] push_end;
      logic [31:0] offset;
   } stk_cmd_type;

endpackage
`default_nettype wire

/* rtl/bertlv_if.sv */
// Word channels of the BER-TLV stream parser: raw input bytes and parse results.
`default_nettype none
interface bertlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface bertlv_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] tag;
   logic [2:0]  tag_bytes;
   logic [31:0] length;
   logic        constructed;
   logic [3:0]  depth;
   logic [7:0]  value_byte;
   logic        value_last;
   logic        message_end;
   logic [2:0]  error_code;

   modport source (output valid, output kind, output tag, output tag_bytes, output length,
                   output constructed, output depth, output value_byte, output value_last,
                   output message_end, output error_code, input ready);
   modport sink   (input valid, input kind, input tag, input tag_bytes, input length,
                   input constructed, input depth, input value_byte, input value_last,
                   input message_end, input error_code, output ready);
endinterface
`default_nettype wire

/* rtl/ber_tlv_stream_parser.sv */
// Top level of the BER-TLV stream parser: input word register, parser, result register.
//
// Streaming BER-TLV parser. Each input word carries one raw message byte and
// an end-of-message flag; each word yields at most one result word: an
// element header (tag, tag byte count, length, constructed flag, depth), a
// primitive value byte passed through, or an error. Throughput is one word
// per cycle while results are taken. Each accepted word is held in an input
// register, decoded by a single combinational pass through the parser and
// the nesting stack, and any result lands in a result register.
// The result register and the input register are both free to move in the
// same cycle, so req_stream.ready stays high while rsp_stream.ready is high;
// a stalled result holds the input register and then ready drops. The
// nesting stack keeps MAX_DEPTH end offsets in flip-flops; several levels
// that end on the same byte close together on that byte. After the first
// fault the parser reports one error and drops words without results until
// the end-of-message word, which always returns it to its start state. A
// message ending with an element or level still open reports truncation in
// place of that word's result. Offsets count from the first word after the
// previous end of message and wrap at 2^32.
`default_nettype none
module ber_tlv_stream_parser
   import bertlv_pkg::*;
#(
   parameter int MAX_DEPTH     = 8,
   parameter int MAX_TAG_BYTES = 4,
   parameter int MAX_LEN_BYTES = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bertlv_req_if.sink       req_stream,
   bertlv_rsp_if.source     rsp_stream
);
   localparam int DW = $clog2(MAX_DEPTH + 1);

   // input word register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eom_ff;

   // result word register
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   logic          out_free;
   logic          advance;
   logic          emit;
   rsp_type       result;
   stk_cmd_type   cmd;
   logic [DW-1:0] depth;
   logic [DW-1:0] new_depth;
   logic [31:0]   top_end;

   // Advance the held word whenever the result register can take its outcome.
   assign out_free         = !rsp_valid_ff || rsp_stream.ready;
   assign advance          = in_valid_ff && out_free;
   assign req_stream.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_stream.ready) begin
         in_valid_ff <= req_stream.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_stream.valid && req_stream.ready) begin
         in_byte_ff <= req_stream.data_byte;
         in_eom_ff  <= req_stream.end_of_message;
      end
   end

   bertlv_core #(
      .MAX_DEPTH     (MAX_DEPTH),
      .MAX_TAG_BYTES (MAX_TAG_BYTES),
      .MAX_LEN_BYTES (MAX_LEN_BYTES)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .data_byte      (in_byte_ff),
      .end_of_message (in_eom_ff),
      .depth          (depth),
      .top_end        (top_end),
      .new_depth      (new_depth),
      .cmd            (cmd),
      .emit           (emit),
      .result         (result)
   );

   bertlv_stack #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cmd       (cmd),
      .depth     (depth),
      .top_end   (top_end),
      .new_depth (new_depth)
   );

   // Load a result when the word produces one; drop valid once it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_stream.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_stream.valid       = rsp_valid_ff;
   assign rsp_stream.kind        = rsp_ff.kind;
   assign rsp_stream.tag         = rsp_ff.tag;
   assign rsp_stream.tag_bytes   = rsp_ff.tag_bytes;
   assign rsp_stream.length      = rsp_ff.length;
   assign rsp_stream.constructed = rsp_ff.constructed;
   assign rsp_stream.depth       = rsp_ff.depth;
   assign rsp_stream.value_byte  = rsp_ff.value_byte;
   assign rsp_stream.value_last  = rsp_ff.value_last;
   assign rsp_stream.message_end = rsp_ff.message_end;
   assign rsp_stream.error_code  = rsp_ff.error_code;

   // An end-of-message word always leaves the nesting stack empty.
   a_eom_clears_stack: assert property (
      @(posedge clock) disable iff (reset)
      advance && in_eom_ff |=> depth == '0)
      else $error("nesting stack not empty after end of message");

   // The stack never grows past its configured depth.
   a_depth_bounded: assert property (
      @(posedge clock) disable iff (reset)
      depth <= DW'(MAX_DEPTH))
      else $error("nesting depth beyond limit");

   // An error result always carries a nonzero code, and only error results do.
   a_error_code_kind: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.kind == KIND_ERROR) == (rsp_ff.error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   // A word waiting on a stalled result stays in the input register.
   a_input_held: assert property (
      @(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eom_ff))
      else $error("input word lost while result stalled");

endmodule
`default_nettype wire

/* rtl/bertlv_stack.sv */
// Nesting stack of element end offsets with multi-level close detection.
`default_nettype none
module bertlv_stack
   import bertlv_pkg::*;
#(
   parameter int MAX_DEPTH = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire stk_cmd_type                       cmd,
   output logic [$clog2(MAX_DEPTH+1)-1:0]         depth,
   output logic [31:0]                            top_end,
   output logic [$clog2(MAX_DEPTH+1)-1:0]         new_depth
);
   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [31:0]   ends_ff [MAX_DEPTH];
   logic [DW-1:0] depth_ff;
   logic [DW-1:0] depth_in;
   logic [DW-1:0] pushed_depth;
   logic [DW-1:0] popped_depth;

   assign depth   = depth_ff;
   assign top_end = ends_ff[IW'(depth_ff - DW'(1))];

   // Levels close from the top down while their stored end equals the new offset.
   always_comb begin
      logic [31:0] ent;
      pushed_depth = depth_ff + (cmd.push ? DW'(1) : DW'(0));
      popped_depth = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         ent = (cmd.push && (DW'(i) == depth_ff)) ? cmd.push_end : ends_ff[i];
         if ((DW'(i) < pushed_depth) && (ent != cmd.offset))
            popped_depth = DW'(i + 1);
      end
      new_depth = cmd.pop ? popped_depth : pushed_depth;
      depth_in  = cmd.restart ? '0 : new_depth;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (advance) begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && cmd.push && !cmd.restart) begin
         ends_ff[IW'(depth_ff)] <= cmd.push_end;
      end
   end

endmodule
`default_nettype wire

/* rtl/bertlv_core.sv */
// Tag, length and value parsing state with per-byte result decode.
`default_nettype none
module bertlv_core
   import bertlv_pkg::*;
#(
   parameter int MAX_DEPTH     = 8,
   parameter int MAX_TAG_BYTES = 4,
   parameter int MAX_LEN_BYTES = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic [7:0]                        data_byte,
   input  wire logic                              end_of_message,
   input  wire logic [$clog2(MAX_DEPTH+1)-1:0]    depth,
   input  wire logic [31:0]                       top_end,
   input  wire logic [$clog2(MAX_DEPTH+1)-1:0]    new_depth,
   output stk_cmd_type                            cmd,
   output logic                                   emit,
   output rsp_type                                result
);
   localparam int DW  = $clog2(MAX_DEPTH + 1);
   localparam int TCW = $clog2(MAX_TAG_BYTES + 1);
   localparam int LCW = $clog2(MAX_LEN_BYTES + 1);

   phase_type    phase_ff,    phase_in;
   logic [31:0]  tag_acc_ff,  tag_acc_in;
   logic [TCW-1:0] tag_cnt_ff, tag_cnt_in;
   logic         cons_ff,     cons_in;
   logic [31:0]  len_acc_ff,  len_acc_in;
   logic [LCW-1:0] len_left_ff, len_left_in;
   logic [31:0]  val_left_ff, val_left_in;
   logic [31:0]  offset_ff,   offset_in;
   logic         hold_ff,     hold_in;

   always_comb begin
      logic        partial;
      logic        hdr;
      logic        done;
      logic        restart;
      logic [2:0]  err;
      logic [6:0]  len_cnt;
      logic [32:0] off_p1;
      logic [32:0] elem_end;

      phase_in    = phase_ff;
      tag_acc_in  = tag_acc_ff;
      tag_cnt_in  = tag_cnt_ff;
      cons_in     = cons_ff;
      len_acc_in  = len_acc_ff;
      len_left_in = len_left_ff;
      val_left_in = val_left_ff;
      offset_in   = offset_ff;
      hold_in     = hold_ff;
      partial     = 1'b0;
      hdr         = 1'b0;
      done        = 1'b0;
      restart     = 1'b0;
      err         = ERR_NONE;
      len_cnt     = data_byte[6:0];
      off_p1      = {1'b0, offset_ff} + 33'd1;
      elem_end    = '0;
      emit        = 1'b0;
      result      = '0;
      cmd         = '0;
      cmd.offset  = off_p1[31:0];

      if (hold_ff) begin
         // drop bytes until the message ends
         restart = end_of_message;
      end else begin
         offset_in = off_p1[31:0];
         case (phase_ff)
            PH_TAG_MORE: begin
               if (tag_cnt_ff >= TCW'(MAX_TAG_BYTES)) begin
                  err = ERR_TOO_LONG;
               end else begin
                  tag_acc_in = {tag_acc_ff[23:0], data_byte};
                  tag_cnt_in = tag_cnt_ff + TCW'(1);
                  if (!data_byte[MORE_BIT])
                     phase_in = PH_LEN_FIRST;
                  partial = 1'b1;
               end
            end
            PH_LEN_FIRST: begin
               len_acc_in = '0;
               if (!data_byte[MORE_BIT]) begin
                  len_acc_in = {25'd0, data_byte[6:0]};
                  hdr        = 1'b1;
               end else if (len_cnt > 7'(MAX_LEN_BYTES)) begin
                  err = ERR_TOO_LONG;
               end else if (len_cnt == 7'd0) begin
                  hdr = 1'b1;
               end else begin
                  len_left_in = LCW'(len_cnt);
                  phase_in    = PH_LEN_MORE;
                  partial     = 1'b1;
               end
            end
            PH_LEN_MORE: begin
               if (len_acc_ff[31:24] != 8'd0) begin
                  err = ERR_TOO_LONG;
               end else begin
                  len_acc_in = {len_acc_ff[23:0], data_byte};
                  if (len_left_ff <= LCW'(1)) begin
                     len_left_in = '0;
                     hdr         = 1'b1;
                  end else begin
                     len_left_in = len_left_ff - LCW'(1);
                     partial     = 1'b1;
                  end
               end
            end
            PH_VALUE: begin
               emit              = 1'b1;
               result.kind       = KIND_VALUE;
               result.depth      = RSP_DEPTH_W'(depth);
               result.value_byte = data_byte;
               if (val_left_ff <= 32'd1) begin
                  val_left_in       = '0;
                  result.value_last = 1'b1;
                  done              = 1'b1;
                  phase_in          = PH_TAG_FIRST;
               end else begin
                  val_left_in = val_left_ff - 32'd1;
               end
            end
            default: begin
               tag_acc_in = {24'd0, data_byte};
               tag_cnt_in = TCW'(1);
               cons_in    = data_byte[TAG_CONS_BIT];
               phase_in   = (data_byte[4:0] == TAG_LOW_ALL) ? PH_TAG_MORE : PH_LEN_FIRST;
               partial    = 1'b1;
            end
         endcase

         // a header still open must stay inside its enclosing element
         if (partial && (depth != '0) && (off_p1 >= {1'b0, top_end}))
            err = ERR_OVERRUN;

         if (hdr && (err == ERR_NONE)) begin
            elem_end = off_p1 + {1'b0, len_acc_in};
            if ((depth != '0) && (elem_end > {1'b0, top_end})) begin
               err = ERR_OVERRUN;
            end else if (cons_ff && (depth >= DW'(MAX_DEPTH))) begin
               err = ERR_TOO_DEEP;
            end else begin
               emit               = 1'b1;
               result.kind        = KIND_HEADER;
               result.tag         = tag_acc_in;
               result.tag_bytes   = 3'(tag_cnt_in);
               result.length      = len_acc_in;
               result.constructed = cons_ff;
               result.depth       = RSP_DEPTH_W'(depth);
               phase_in           = PH_TAG_FIRST;
               if (cons_ff) begin
                  cmd.push     = 1'b1;
                  cmd.push_end = elem_end[31:0];
                  done         = (len_acc_in == 32'd0);
               end else if (len_acc_in != 32'd0) begin
                  val_left_in = len_acc_in;
                  phase_in    = PH_VALUE;
               end else begin
                  done = 1'b1;
               end
            end
         end

         cmd.pop = done;

         if (err != ERR_NONE) begin
            emit              = 1'b1;
            result            = '0;
            result.kind       = KIND_ERROR;
            result.depth      = RSP_DEPTH_W'(depth);
            result.error_code = err;
            if (end_of_message) begin
               result.message_end = 1'b1;
               restart            = 1'b1;
            end else begin
               hold_in = 1'b1;
            end
         end else if (end_of_message) begin
            if (!((phase_in == PH_TAG_FIRST) && (new_depth == '0))) begin
               emit              = 1'b1;
               result            = '0;
               result.kind       = KIND_ERROR;
               result.depth      = RSP_DEPTH_W'(new_depth);
               result.error_code = ERR_TRUNCATED;
            end
            result.message_end = 1'b1;
            restart            = 1'b1;
         end
      end

      if (restart) begin
         phase_in    = PH_TAG_FIRST;
         tag_acc_in  = '0;
         tag_cnt_in  = '0;
         cons_in     = 1'b0;
         len_acc_in  = '0;
         len_left_in = '0;
         val_left_in = '0;
         offset_in   = '0;
         hold_in     = 1'b0;
      end
      cmd.restart = restart;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TAG_FIRST;
         tag_acc_ff  <= '0;
         tag_cnt_ff  <= '0;
         cons_ff     <= 1'b0;
         len_acc_ff  <= '0;
         len_left_ff <= '0;
         val_left_ff <= '0;
         offset_ff   <= '0;
         hold_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         tag_acc_ff  <= tag_acc_in;
         tag_cnt_ff  <= tag_cnt_in;
         cons_ff     <= cons_in;
         len_acc_ff  <= len_acc_in;
         len_left_ff <= len_left_in;
         val_left_ff <= val_left_in;
         offset_ff   <= offset_in;
         hold_ff     <= hold_in;
      end
   end

endmodule
`default_nettype wire
